/* hdl/pdh_pkg.sv */
// Package for the pair-distance histogram: request and result structs,
// operation codes, configuration register indexes and their reset values.
// No dependencies; used by pair_distance_histogram.
package pdh_pkg;

    // Operation codes carried in a request.
    localparam logic [2:0] OP_LOAD_NORM   = 3'd0;
    localparam logic [2:0] OP_ACC_PAIR    = 3'd1;
    localparam logic [2:0] OP_ADD_WEIGHT  = 3'd2;
    localparam logic [2:0] OP_READ_BIN    = 3'd3;
    localparam logic [2:0] OP_READ_WEIGHT = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CUTOFF  = 2'd0;
    localparam logic [1:0] CFG_INV_BIN = 2'd1;
    localparam logic [1:0] CFG_SPECIES = 2'd2;
    localparam logic [1:0] CFG_BINS    = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [31:0] CUTOFF_RESET  = 32'd0;
    localparam logic [31:0] INV_BIN_RESET = 32'd65536;
    localparam logic [2:0]  SPECIES_RESET = 3'd1;
    localparam logic [8:0]  BINS_RESET    = 9'd256;

    // One request.
    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] distance;
        logic [1:0]  species_a;
        logic [1:0]  species_b;
        logic [3:0]  channel;
        logic [7:0]  bin_index;
        logic [31:0] word_value;
    } t_req;

    // One result.
    typedef struct packed {
        logic [63:0] read_value;
        logic        counted;
        logic        index_error;
        logic        saturated;
    } t_rsp;

endpackage

/* hdl/pdh_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module pdh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/pair_distance_histogram.sv */
// Top level of the weighted pair-distance histogram.
// Depends on pdh_pkg and pdh_ram (norm word table and histogram sums).
//
//  Channel   Ports                               Handshake
//  request   i_start, o_busy, i_req              taken when i_start && !o_busy
//  result    o_done, o_rsp                       one-cycle strobe, no back-pressure
//  config    i_cfg_we, i_cfg_index, i_cfg_data   written when i_cfg_we is high
//
// Every request passes through capture, multiply and decode, memory read, then
// read-modify-write of the histogram entry. The registered read data of the
// memories and the shared read-modify-write path set that sequence.
// After reset the histogram memory is cleared one entry per cycle, all HIST_DEPTH
// entries (2560 with the default parameters), with o_busy high throughout.
// The result strobe o_done rises in the cycle o_busy falls; the receiver
// cannot stall, and the next request may be taken in that same cycle.
module pair_distance_histogram
    import pdh_pkg::*;
#(
    parameter int MAX_SPECIES = 4,
    parameter int MAX_BINS    = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  t_req        i_req,
    output logic        o_done,
    output t_rsp        o_rsp,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int NPAIR      = MAX_SPECIES * (MAX_SPECIES + 1) / 2;
    localparam int NORM_CH    = NPAIR + 1;
    localparam int NORM_DEPTH = NORM_CH * MAX_BINS;
    localparam int HIST_DEPTH = NPAIR * MAX_BINS;
    localparam int NAW        = $clog2(NORM_DEPTH);
    localparam int HAW        = $clog2(HIST_DEPTH);
    localparam int NSW        = $clog2(MAX_SPECIES + 1);
    localparam int SQW        = 2 * NSW;
    localparam int PCW        = $clog2(NPAIR + 1);
    localparam int BW         = $clog2(MAX_BINS);
    localparam int NBW        = $clog2(MAX_BINS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_ADDR  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]      r_state, n_state;
    logic [HAW-1:0]  r_clr;
    logic [31:0]     r_cutoff, r_inv_bin;
    logic [2:0]      r_species;
    logic [8:0]      r_bins;
    logic [63:0]     r_weight;
    t_req            r_req;
    logic [63:0]     r_prod;
    logic [PCW-1:0]  r_pair;
    logic            r_err, r_hit;
    logic [HAW-1:0]  r_haddr;
    logic            r_done;
    t_rsp            r_rsp, n_rsp;

    logic [NSW-1:0]  w_ns;
    logic [NBW-1:0]  w_nb;
    logic [PCW-1:0]  w_npairs;
    logic [1:0]      w_lo, w_hi;
    logic [SQW-1:0]  w_n, w_d, w_tri_n, w_tri_d;
    logic [PCW-1:0]  w_pair;
    logic            w_err, w_hit;
    logic [BW-1:0]   w_bin, w_req_bin;
    logic [NAW-1:0]  w_norm_raddr, w_norm_waddr;
    logic            w_norm_we;
    logic [HAW-1:0]  w_hist_addr;
    logic            w_hist_we;
    logic [HAW-1:0]  w_hist_waddr;
    logic [63:0]     w_hist_wdata;
    logic [31:0]     w_norm_rd;
    logic [63:0]     w_hist_rd;
    logic [64:0]     w_sum, w_wsum;
    logic [63:0]     w_sum_sat;

    // Effective species and bin counts, clamped to the supported range.
    always_comb begin
        if (r_species == 3'd0) begin
            w_ns = NSW'(1);
        end else if (32'(r_species) > 32'(MAX_SPECIES)) begin
            w_ns = NSW'(MAX_SPECIES);
        end else begin
            w_ns = NSW'(r_species);
        end
        if (r_bins == 9'd0) begin
            w_nb = NBW'(1);
        end else if (32'(r_bins) > 32'(MAX_BINS)) begin
            w_nb = NBW'(MAX_BINS);
        end else begin
            w_nb = NBW'(r_bins);
        end
        w_npairs = PCW'((SQW'(w_ns) * (SQW'(w_ns) + SQW'(1))) >> 1);
    end

    // Triangular species-pair index of the captured request.
    always_comb begin
        if (r_req.species_a < r_req.species_b) begin
            w_lo = r_req.species_a;
            w_hi = r_req.species_b;
        end else begin
            w_lo = r_req.species_b;
            w_hi = r_req.species_a;
        end
        w_n     = SQW'(w_ns);
        w_d     = w_n - SQW'(w_lo);
        w_tri_n = (w_n * (w_n - SQW'(1))) >> 1;
        w_tri_d = (w_d * (w_d - SQW'(1))) >> 1;
        w_pair  = PCW'(w_tri_n - w_tri_d + SQW'(w_hi));
    end

    // Range checks and the cutoff test per operation.
    always_comb begin
        w_err = 1'b0;
        w_hit = 1'b0;
        case (r_req.operation)
            OP_LOAD_NORM: begin
                w_err = (32'(r_req.channel) > 32'(w_npairs))
                     || (32'(r_req.bin_index) >= 32'(w_nb));
            end
            OP_ACC_PAIR: begin
                w_err = (32'(r_req.species_a) >= 32'(w_ns))
                     || (32'(r_req.species_b) >= 32'(w_ns));
                w_hit = !w_err && (r_req.distance < r_cutoff);
            end
            OP_READ_BIN: begin
                w_err = (32'(r_req.channel) >= 32'(w_npairs))
                     || (32'(r_req.bin_index) >= 32'(w_nb));
            end
            default: begin
                w_err = 1'b0;
            end
        endcase
    end

    // Bin of a pair, clamped to the last bin in use, and memory addresses.
    always_comb begin
        if (r_prod[63:32] >= 32'(w_nb)) begin
            w_bin = BW'(w_nb - NBW'(1));
        end else begin
            w_bin = BW'(r_prod[63:32]);
        end
        w_req_bin    = BW'(r_req.bin_index);
        w_norm_raddr = (NAW'(r_pair) + NAW'(1)) * NAW'(MAX_BINS) + NAW'(w_bin);
        w_norm_waddr = NAW'(r_req.channel) * NAW'(MAX_BINS) + NAW'(w_req_bin);
        w_norm_we    = (r_state == S_ADDR) && (r_req.operation == OP_LOAD_NORM) && !r_err;
        if (r_req.operation == OP_ACC_PAIR) begin
            w_hist_addr = HAW'(r_pair) * HAW'(MAX_BINS) + HAW'(w_bin);
        end else begin
            w_hist_addr = HAW'(r_req.channel) * HAW'(MAX_BINS) + HAW'(w_req_bin);
        end
    end

    // Saturating sums for the histogram entry and the weight total.
    always_comb begin
        w_sum     = {1'b0, w_hist_rd} + 65'(w_norm_rd);
        w_sum_sat = w_sum[64] ? {64{1'b1}} : w_sum[63:0];
        w_wsum    = {1'b0, r_weight} + 65'(r_req.word_value);
    end

    // Histogram write port: clearing pass or write-back of an accumulated pair.
    always_comb begin
        w_hist_we    = (r_state == S_CLEAR) || ((r_state == S_DONE) && r_hit);
        w_hist_waddr = (r_state == S_CLEAR) ? r_clr : r_haddr;
        w_hist_wdata = (r_state == S_CLEAR) ? 64'd0 : w_sum_sat;
    end

    pdh_ram #(
        .WIDTH (32),
        .DEPTH (NORM_DEPTH)
    ) u_norm_ram (
        .i_clk   (i_clk),
        .i_we    (w_norm_we),
        .i_waddr (w_norm_waddr),
        .i_wdata (r_req.word_value),
        .i_raddr (w_norm_raddr),
        .o_rdata (w_norm_rd)
    );

    pdh_ram #(
        .WIDTH (64),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_hist_we),
        .i_waddr (w_hist_waddr),
        .i_wdata (w_hist_wdata),
        .i_raddr (w_hist_addr),
        .o_rdata (w_hist_rd)
    );

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_EXEC;
                end
            end
            S_CLEAR: begin
                if (r_clr == HAW'(HIST_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_EXEC: begin
                n_state = S_ADDR;
            end
            S_ADDR: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result of the request in its final cycle.
    always_comb begin
        n_rsp = '0;
        case (r_req.operation)
            OP_LOAD_NORM: begin
                n_rsp.index_error = r_err;
            end
            OP_ACC_PAIR: begin
                n_rsp.index_error = r_err;
                n_rsp.counted     = r_hit;
                n_rsp.saturated   = r_hit && w_sum[64];
            end
            OP_ADD_WEIGHT: begin
                n_rsp.saturated = w_wsum[64];
            end
            OP_READ_BIN: begin
                n_rsp.index_error = r_err;
                n_rsp.read_value  = r_err ? 64'd0 : w_hist_rd;
            end
            OP_READ_WEIGHT: begin
                n_rsp.read_value = r_weight;
            end
            default: begin
                n_rsp = '0;
            end
        endcase
    end

    // Control state, configuration registers and the weight total.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_done    <= 1'b0;
            r_weight  <= 64'd0;
            r_cutoff  <= CUTOFF_RESET;
            r_inv_bin <= INV_BIN_RESET;
            r_species <= SPECIES_RESET;
            r_bins    <= BINS_RESET;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_DONE);
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + HAW'(1);
            end
            if ((r_state == S_DONE) && (r_req.operation == OP_ADD_WEIGHT)) begin
                r_weight <= w_wsum[64] ? {64{1'b1}} : w_wsum[63:0];
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CUTOFF:  r_cutoff  <= i_cfg_data;
                    CFG_INV_BIN: r_inv_bin <= i_cfg_data;
                    CFG_SPECIES: r_species <= i_cfg_data[2:0];
                    CFG_BINS:    r_bins    <= i_cfg_data[8:0];
                    default:     r_cutoff  <= r_cutoff;
                endcase
            end
        end
    end

    // Request pipeline registers.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_start) begin
            r_req <= i_req;
        end
        if (r_state == S_EXEC) begin
            r_prod <= 64'(r_req.distance) * 64'(r_inv_bin);
            r_pair <= w_pair;
            r_err  <= w_err;
            r_hit  <= w_hit;
        end
        if (r_state == S_ADDR) begin
            r_haddr <= w_hist_addr;
        end
        if (r_state == S_DONE) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // A request taken in idle always moves on to the multiply stage.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (r_state == S_EXEC))
        else $error("accepted request did not enter the multiply stage");

    // A result strobe follows only the final stage of a request.
    a_done_from_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_state) == S_DONE))
        else $error("result strobe without a finished request");

    // The histogram is written only by the clearing pass or a counted pair.
    a_hist_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hist_we |-> ((r_state == S_CLEAR) || ((r_state == S_DONE)
            && (r_req.operation == OP_ACC_PAIR) && !r_err)))
        else $error("unexpected histogram write");

    // A pair is never both counted and flagged out of range.
    a_count_vs_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_rsp.counted && o_rsp.index_error))
        else $error("pair counted despite an index error");

endmodule
